// File: sv/fecs_pkg.sv
// ----------------------------------------------------------------------------
// fecs_pkg: shared types and constants of the fire effect cell store
// Holds the request codes, level constants, the 37-entry colour palette and
// the command and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fecs_pkg;

    localparam int CELL_W  = 16;
    localparam int LEVEL_W = 6;
    localparam int OP_W    = 2;
    localparam int DECAY_W = 2;
    localparam int COLOUR_W = 8;

    // Request codes; the unused code behaves as a read.
    localparam logic [OP_W-1:0] OP_SPREAD = 2'd0;
    localparam logic [OP_W-1:0] OP_IGNITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [LEVEL_W-1:0] START_LEVEL = 6'd20;
    localparam logic [LEVEL_W-1:0] TOP_LEVEL   = 6'd36;
    localparam logic [DECAY_W-1:0] DECAY_MAX   = 2'd2;

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } ctrl_status_t;

    // Fire palette, dark grey through red and yellow to white.
    function automatic rgb_t palette_lookup(input logic [LEVEL_W-1:0] level);
        rgb_t c;
        case (level)
            6'd0:    c = '{8'd7,   8'd7,   8'd7};
            6'd1:    c = '{8'd31,  8'd7,   8'd7};
            6'd2:    c = '{8'd47,  8'd15,  8'd7};
            6'd3:    c = '{8'd71,  8'd15,  8'd7};
            6'd4:    c = '{8'd87,  8'd23,  8'd7};
            6'd5:    c = '{8'd103, 8'd31,  8'd7};
            6'd6:    c = '{8'd119, 8'd31,  8'd7};
            6'd7:    c = '{8'd143, 8'd39,  8'd7};
            6'd8:    c = '{8'd159, 8'd47,  8'd7};
            6'd9:    c = '{8'd175, 8'd63,  8'd7};
            6'd10:   c = '{8'd191, 8'd71,  8'd7};
            6'd11:   c = '{8'd199, 8'd71,  8'd7};
            6'd12:   c = '{8'd223, 8'd79,  8'd7};
            6'd13:   c = '{8'd223, 8'd87,  8'd7};
            6'd14:   c = '{8'd223, 8'd87,  8'd7};
            6'd15:   c = '{8'd215, 8'd95,  8'd7};
            6'd16:   c = '{8'd215, 8'd95,  8'd7};
            6'd17:   c = '{8'd215, 8'd103, 8'd15};
            6'd18:   c = '{8'd207, 8'd111, 8'd15};
            6'd19:   c = '{8'd207, 8'd119, 8'd15};
            6'd20:   c = '{8'd207, 8'd127, 8'd15};
            6'd21:   c = '{8'd207, 8'd135, 8'd23};
            6'd22:   c = '{8'd199, 8'd135, 8'd23};
            6'd23:   c = '{8'd199, 8'd143, 8'd23};
            6'd24:   c = '{8'd199, 8'd151, 8'd31};
            6'd25:   c = '{8'd191, 8'd159, 8'd31};
            6'd26:   c = '{8'd191, 8'd159, 8'd31};
            6'd27:   c = '{8'd191, 8'd167, 8'd39};
            6'd28:   c = '{8'd191, 8'd167, 8'd39};
            6'd29:   c = '{8'd191, 8'd175, 8'd47};
            6'd30:   c = '{8'd183, 8'd175, 8'd47};
            6'd31:   c = '{8'd183, 8'd183, 8'd47};
            6'd32:   c = '{8'd183, 8'd183, 8'd55};
            6'd33:   c = '{8'd207, 8'd207, 8'd111};
            6'd34:   c = '{8'd223, 8'd223, 8'd159};
            6'd35:   c = '{8'd239, 8'd239, 8'd199};
            default: c = '{8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

endpackage

// File: sv/fecs_ram.sv
// ----------------------------------------------------------------------------
// fecs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fecs_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 57600
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/fecs_ctrl.sv
// ----------------------------------------------------------------------------
// fecs_ctrl: sequencing state machine of the fire effect cell store
// Runs the clearing pass after reset, then takes one request at a time and
// resolves it once the memory read has returned and the output is free.
// ----------------------------------------------------------------------------
module fecs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fecs_pkg::ctrl_status_t status,
    output fecs_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR   = 3'b001,
        ST_IDLE    = 3'b010,
        ST_RESOLVE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.clear_wr = 1'b0;
        cmd.load     = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A request that is taken is resolved in the very next cycle or held there.
    a_load_then_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_RESOLVE))
        else $error("accepted request did not move to resolve");

    // The clearing pass and request handling never overlap.
    a_no_clear_with_request: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> (!cmd.load && !cmd.finish))
        else $error("clearing write issued alongside a request");

endmodule

// File: sv/fecs_datapath.sv
// ----------------------------------------------------------------------------
// fecs_datapath: request registers, intensity memory and result register
// Works out the source cell on acceptance, reads it, then forms the level,
// target cell, write-back and palette colour of the result.
// ----------------------------------------------------------------------------
module fecs_datapath #(
    parameter int COLUMNS = 320,
    parameter int ROWS    = 180
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fecs_pkg::ctrl_cmd_t               cmd,
    output fecs_pkg::ctrl_status_t            status,
    input  logic [fecs_pkg::OP_W-1:0]         in_op,
    input  logic [fecs_pkg::CELL_W-1:0]       in_cell,
    input  logic [fecs_pkg::DECAY_W-1:0]      in_decay,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_wrote,
    output logic [fecs_pkg::CELL_W-1:0]       out_cell,
    output logic [fecs_pkg::LEVEL_W-1:0]      out_level,
    output fecs_pkg::rgb_t                    out_rgb
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int REACH  = 1 << fecs_pkg::CELL_W;
    // Cells beyond the reach of a 16-bit index are never addressed.
    localparam int DEPTH  = (CELLS > REACH) ? REACH : CELLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = $clog2(CELLS + COLUMNS + REACH);

    logic [fecs_pkg::OP_W-1:0]    op_reg;
    logic [fecs_pkg::CELL_W-1:0]  cell_reg;
    logic [fecs_pkg::DECAY_W-1:0] decay_reg;
    logic                         in_grid_reg;
    logic                         below_ok_reg;
    logic                         below_far_reg;

    logic [SUM_W-1:0]             below_sum;
    logic                         below_ok;
    logic                         below_far;
    logic                         in_grid;
    logic [fecs_pkg::DECAY_W-1:0] decay_sat;
    logic [ADDR_W-1:0]            rd_addr;

    logic [ADDR_W-1:0]            clr_addr_reg;
    logic [ADDR_W-1:0]            clr_addr_next;

    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [fecs_pkg::LEVEL_W-1:0] mem_wdata;
    logic [fecs_pkg::LEVEL_W-1:0] mem_rdata;

    logic [fecs_pkg::LEVEL_W-1:0] src_level;
    logic                         res_wrote;
    logic [fecs_pkg::CELL_W-1:0]  res_cell;
    logic [fecs_pkg::LEVEL_W-1:0] res_level;
    logic [fecs_pkg::LEVEL_W-1:0] pal_index;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_wrote_reg;
    logic [fecs_pkg::CELL_W-1:0]  out_cell_reg;
    logic [fecs_pkg::LEVEL_W-1:0] out_level_reg;
    fecs_pkg::rgb_t               out_rgb_reg;

    // Source cell decision on the incoming request.
    assign below_sum = SUM_W'(in_cell) + SUM_W'(COLUMNS);
    assign below_ok  = below_sum < SUM_W'(CELLS);
    assign below_far = below_sum >= SUM_W'(REACH);
    assign in_grid   = SUM_W'(in_cell) < SUM_W'(CELLS);
    assign decay_sat = (in_decay > fecs_pkg::DECAY_MAX) ? fecs_pkg::DECAY_MAX : in_decay;
    assign rd_addr   = (in_op == fecs_pkg::OP_SPREAD && below_ok) ?
                       below_sum[ADDR_W-1:0] : in_cell[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= in_op;
            cell_reg      <= in_cell;
            decay_reg     <= decay_sat;
            in_grid_reg   <= in_grid;
            below_ok_reg  <= below_ok;
            below_far_reg <= below_far;
        end
    end

    // A cell past the reach of the index is never written, so it still holds
    // its starting level.
    assign src_level = below_far_reg ? fecs_pkg::START_LEVEL : mem_rdata;

    // Result formation once the source level is back from memory.
    always_comb
    begin
        res_wrote = 1'b0;
        res_cell  = cell_reg;
        res_level = mem_rdata;
        if (!in_grid_reg)
        begin
            res_level = '0;
        end
        else if (op_reg == fecs_pkg::OP_SPREAD && below_ok_reg)
        begin
            res_wrote = 1'b1;
            res_level = (src_level >= fecs_pkg::LEVEL_W'(decay_reg)) ?
                        src_level - fecs_pkg::LEVEL_W'(decay_reg) : '0;
            res_cell  = (cell_reg >= fecs_pkg::CELL_W'(decay_reg)) ?
                        cell_reg - fecs_pkg::CELL_W'(decay_reg) : '0;
        end
        else if (op_reg == fecs_pkg::OP_IGNITE)
        begin
            res_wrote = 1'b1;
            res_level = fecs_pkg::TOP_LEVEL;
        end
    end

    assign pal_index = (res_level > fecs_pkg::TOP_LEVEL) ? fecs_pkg::TOP_LEVEL : res_level;

    // Clearing pass address.
    assign clr_addr_next = clr_addr_reg + ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign status.clr_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    assign mem_we    = cmd.clear_wr || (cmd.finish && res_wrote);
    assign mem_waddr = cmd.clear_wr ? clr_addr_reg : res_cell[ADDR_W-1:0];
    assign mem_wdata = cmd.clear_wr ? fecs_pkg::START_LEVEL : res_level;

    fecs_ram #(
        .WIDTH (fecs_pkg::LEVEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.load),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    // Output register.
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_wrote_reg <= res_wrote;
            out_cell_reg  <= res_cell;
            out_level_reg <= res_level;
            out_rgb_reg   <= fecs_pkg::palette_lookup(pal_index);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_wrote = out_wrote_reg;
    assign out_cell  = out_cell_reg;
    assign out_level = out_level_reg;
    assign out_rgb   = out_rgb_reg;

    // Requests on cells outside the grid must never write the store.
    a_no_write_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !in_grid_reg) |-> !mem_we)
        else $error("write issued for a cell outside the grid");

    // Every level stored stays within the palette range.
    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_wdata <= fecs_pkg::TOP_LEVEL))
        else $error("level above the top of the palette written");

endmodule

// File: sv/fire_effect_cell_store_top.sv
// ----------------------------------------------------------------------------
// fire_effect_cell_store_top: fire intensity grid with spread, ignite and read
// Flow: each request goes through the registered read of the intensity memory before
// it is resolved, and its result is loaded into the output register once that register
// is free. A new request is taken only after the previous one has been resolved.
// Reset: the controller sweeps every cell to level 20, one cell a cycle, over
// ROWS * COLUMNS cells (capped at 65536) before the first request is accepted.
// ----------------------------------------------------------------------------
module fire_effect_cell_store_top #(
    parameter int COLUMNS = 320,
    parameter int ROWS    = 180
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] cell_req, [17:16] decay, [23:18] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] target_cell, [21:16] level, [29:22] red,
                                        // [37:30] green, [45:38] blue, [47:46] zero
    output logic [0:0]  m_axis_tuser    // [0] wrote
);

    // The controller sequences each request through two steps: on acceptance
    // the source cell is chosen (the cell one row below for a spread that is
    // not on the bottom row, otherwise the requested cell) and read; in the
    // resolve step the datapath forms the level and target, writes the
    // store back when the request changes a cell, and loads the result
    // register. The result register lets the block take a new request while
    // an earlier result is still waiting downstream; a request only stalls in
    // its resolve step while that register is still occupied.

    fecs_pkg::ctrl_cmd_t    cmd;
    fecs_pkg::ctrl_status_t status;
    fecs_pkg::rgb_t         out_rgb;
    logic                   out_wrote;
    logic [15:0]            out_cell;
    logic [5:0]             out_level;

    fecs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fecs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_axis_tuser),
        .in_cell   (s_axis_tdata[15:0]),
        .in_decay  (s_axis_tdata[17:16]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_wrote (out_wrote),
        .out_cell  (out_cell),
        .out_level (out_level),
        .out_rgb   (out_rgb)
    );

    assign m_axis_tdata = {2'b00, out_rgb.blue, out_rgb.green, out_rgb.red,
                           out_level, out_cell};
    assign m_axis_tuser = out_wrote;

endmodule

// File: verif/tb_fire_effect_cell_store_top.sv
// ----------------------------------------------------------------------------
// tb_fire_effect_cell_store_top: self-checking bench for the fire cell store
// Sends spread, ignite and read requests over the request stream. A tracker
// keeps its own copy of the intensity grid and checks every result field
// against the level and palette colour it expects. Directed requests come
// first, then random requests under four idling patterns.
// ----------------------------------------------------------------------------
module tb_fire_effect_cell_store_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_COLUMNS = 320;
    localparam int GRID_ROWS    = 180;
    localparam int GRID_CELLS   = GRID_COLUMNS * GRID_ROWS;
    localparam int PALETTE_LEN  = 37;

    typedef logic [fecs_pkg::OP_W-1:0]    op_t;
    typedef logic [fecs_pkg::CELL_W-1:0]  cell_t;
    typedef logic [fecs_pkg::DECAY_W-1:0] decay_t;
    typedef logic [fecs_pkg::LEVEL_W-1:0] level_t;

    // The spare request code is not named in the package; the block treats
    // it as a read.
    localparam op_t    OP_SPARE   = 2'd3;
    // A decay of three is out of range and saturates to the maximum.
    localparam decay_t DECAY_OVER = 2'd3;

    localparam int RANDOM_PER_PHASE = 225;
    localparam int PHASE_COUNT      = 4;
    // The reset sweep visits all 57600 cells without a handshake, so the
    // watchdog must allow for well over the whole sweep.
    localparam int WATCHDOG_LIMIT   = 4 * 65536;
    localparam int DRAIN_CYCLES     = 8;

    // One expected result.
    typedef struct {
        bit                               wrote;
        bit [fecs_pkg::CELL_W-1:0]        spot;
        bit [fecs_pkg::LEVEL_W-1:0]       level;
        bit [fecs_pkg::COLOUR_W-1:0]      red;
        bit [fecs_pkg::COLOUR_W-1:0]      green;
        bit [fecs_pkg::COLOUR_W-1:0]      blue;
    } glow_t;

    // ------------------------------------------------------------------------
    // Grid tracker: a private copy of the intensity grid. Each accepted
    // request updates the copy and queues the result it must produce; each
    // result from the block is checked against the oldest queued one.
    // ------------------------------------------------------------------------
    class fire_grid_tracker;

        bit [fecs_pkg::LEVEL_W-1:0] heat [GRID_CELLS];
        bit [23:0]                  ember_rgb [PALETTE_LEN];
        glow_t                      pending_glows [$];

        int failures;
        int requests;
        int writes;
        int outside;
        int floored;
        int bottom_spreads;

        function new();
            // Palette entries packed as {red, green, blue}.
            ember_rgb = '{
                24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707,
                24'h671F07, 24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07,
                24'hBF4707, 24'hC74707, 24'hDF4F07, 24'hDF5707, 24'hDF5707,
                24'hD75F07, 24'hD75F07, 24'hD7670F, 24'hCF6F0F, 24'hCF770F,
                24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17, 24'hC7971F,
                24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
                24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F,
                24'hEFEFC7, 24'hFFFFFF
            };
            foreach (heat[i])
                heat[i] = fecs_pkg::START_LEVEL;
            failures       = 0;
            requests       = 0;
            writes         = 0;
            outside        = 0;
            floored        = 0;
            bottom_spreads = 0;
        endfunction

        function int outstanding();
            return pending_glows.size();
        endfunction

        // Works out what an accepted request does to the grid and queues the
        // result it must produce.
        function void note_request(bit [fecs_pkg::OP_W-1:0] op,
                                   bit [fecs_pkg::CELL_W-1:0] spot,
                                   bit [fecs_pkg::DECAY_W-1:0] decay);
            glow_t       g;
            int unsigned d;
            int unsigned src;
            d = (decay > fecs_pkg::DECAY_MAX) ? fecs_pkg::DECAY_MAX : decay;
            g.wrote = 1'b0;
            g.spot  = spot;
            g.level = '0;
            requests++;
            if (spot >= GRID_CELLS)
            begin
                // Nothing is written and the level reads as zero.
                outside++;
            end
            else if (op == fecs_pkg::OP_SPREAD && spot + GRID_COLUMNS < GRID_CELLS)
            begin
                src     = heat[spot + GRID_COLUMNS];
                g.level = (src >= d) ? level_t'(src - d) : '0;
                g.spot  = (spot >= d) ? cell_t'(spot - d) : '0;
                g.wrote = 1'b1;
                if (src < d)
                    floored++;
                heat[g.spot] = g.level;
                writes++;
            end
            else if (op == fecs_pkg::OP_IGNITE)
            begin
                g.level    = fecs_pkg::TOP_LEVEL;
                g.wrote    = 1'b1;
                heat[spot] = fecs_pkg::TOP_LEVEL;
                writes++;
            end
            else
            begin
                // Reads, the spare code and spreads on the bottom row.
                if (op == fecs_pkg::OP_SPREAD)
                    bottom_spreads++;
                g.level = heat[spot];
            end
            {g.red, g.green, g.blue} = ember_rgb[g.level];
            pending_glows.push_back(g);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(bit wrote, bit [fecs_pkg::CELL_W-1:0] spot,
                                   bit [fecs_pkg::LEVEL_W-1:0] level,
                                   bit [fecs_pkg::COLOUR_W-1:0] red,
                                   bit [fecs_pkg::COLOUR_W-1:0] green,
                                   bit [fecs_pkg::COLOUR_W-1:0] blue);
            glow_t g;
            if (pending_glows.size() == 0)
            begin
                $error("result for cell %0d arrived with no request outstanding", spot);
                failures++;
                return;
            end
            g = pending_glows.pop_front();
            compare_field("wrote", g.wrote, wrote);
            compare_field("target_cell", g.spot, spot);
            compare_field("level", g.level, level);
            compare_field("red", g.red, red);
            compare_field("green", g.green, green);
            compare_field("blue", g.blue, blue);
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, ports and the block itself. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Percentages of cycles in which the sender idles or the receiver stalls.
    int request_idle_pct = 0;
    int result_stall_pct = 0;

    fire_grid_tracker grid_tracker;

    fire_effect_cell_store_top #(
        .COLUMNS (GRID_COLUMNS),
        .ROWS    (GRID_ROWS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sender. Each call starts at a falling edge, optionally idles for a
    // while, presents the request and holds it until the block accepts it.
    // It returns at the falling edge after acceptance, so the valid line is
    // assigned only once in any time step.
    // ------------------------------------------------------------------------
    task automatic send_request(input op_t op, input cell_t spot, input decay_t decay);
        while ($urandom_range(99) < request_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, decay, spot};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        grid_tracker.note_request(op, spot, decay);
        @(negedge clk);
    endtask

    // Drops valid and holds off until every expected result has come back.
    // At least one falling edge passes, so the next request cannot assign
    // valid again in the same time step.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (grid_tracker.outstanding() != 0);
    endtask

    // Random request. Most requests land in one of two small windows of the
    // grid so that spreads chain into one another: the top window reaches
    // the corner where the target index floors at zero, the bottom window
    // covers the bottom row and the last cell. The rest are noise over the
    // whole 16-bit index range, which includes cells outside the grid.
    task automatic pick_request(output op_t op, output cell_t spot, output decay_t decay);
        int roll;
        int row;
        int col;
        roll  = int'($urandom_range(99));
        decay = decay_t'($urandom_range(3));
        if (roll < 10)
        begin
            op   = op_t'($urandom_range(3));
            spot = cell_t'($urandom_range(65535));
        end
        else
        begin
            if (roll < 55)
            begin
                row = int'($urandom_range(15));
                col = int'($urandom_range(7));
            end
            else
            begin
                row = GRID_ROWS - 16 + int'($urandom_range(15));
                col = GRID_COLUMNS - 8 + int'($urandom_range(7));
            end
            spot = cell_t'(row * GRID_COLUMNS + col);
            roll = int'($urandom_range(99));
            if (roll < 62)
                op = fecs_pkg::OP_SPREAD;
            else if (roll < 70)
                op = fecs_pkg::OP_IGNITE;
            else if (roll < 95)
                op = fecs_pkg::OP_READ;
            else
                op = OP_SPARE;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: decides readiness at each falling edge from the stall
    // percentage of the current phase.
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= result_stall_pct);
        end
    end

    // Results are sampled at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            grid_tracker.check_result(m_axis_tuser[0], m_axis_tdata[15:0],
                                      m_axis_tdata[21:16], m_axis_tdata[29:22],
                                      m_axis_tdata[37:30], m_axis_tdata[45:38]);
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts consecutive cycles with no handshake on either side.
    // The loop only ends when the limit is reached.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog expired after %0d cycles without a handshake.", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int     sender_pct [PHASE_COUNT];
        int     receiver_pct [PHASE_COUNT];
        op_t    op;
        cell_t  spot;
        decay_t decay;

        // Phases: no idling, a slow sender, a slow receiver, then light
        // idling on both sides.
        sender_pct   = '{0, 83, 0, 9};
        receiver_pct = '{0, 0, 83, 9};

        grid_tracker = new();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests. The block sweeps its grid after reset, so the
        // first one simply waits for tready.
        send_request(fecs_pkg::OP_READ, 16'd0, 2'd0);           // starting level
        send_request(fecs_pkg::OP_SPREAD, 16'd0, 2'd2);         // target floors at cell zero
        send_request(fecs_pkg::OP_SPREAD, 16'd1, DECAY_OVER);   // decay saturates
        send_request(fecs_pkg::OP_SPREAD, 16'd5, 2'd0);         // spread without decay
        send_request(fecs_pkg::OP_IGNITE, 16'd0, 2'd1);
        send_request(OP_SPARE, 16'd0, 2'd0);                    // spare code reads the cell
        // The bottom row does not spread.
        send_request(fecs_pkg::OP_SPREAD, cell_t'(GRID_CELLS - 1), 2'd1);
        send_request(fecs_pkg::OP_IGNITE, cell_t'(GRID_CELLS - 1), 2'd0);
        send_request(fecs_pkg::OP_READ, cell_t'(GRID_CELLS - 1), 2'd2);
        // Spread from the last cell, which has just been ignited.
        send_request(fecs_pkg::OP_SPREAD, cell_t'(GRID_CELLS - 1 - GRID_COLUMNS), 2'd1);
        // Cells outside the grid, for every request code.
        send_request(fecs_pkg::OP_SPREAD, cell_t'(GRID_CELLS), 2'd2);
        send_request(fecs_pkg::OP_IGNITE, 16'hFFFF, 2'd0);
        send_request(fecs_pkg::OP_READ, 16'hFFFF, DECAY_OVER);
        send_request(OP_SPARE, cell_t'(GRID_CELLS), 2'd1);
        // A chain of spreads, each reading the cell the previous one wrote,
        // brings the level down to zero and then holds it at zero.
        for (int i = 0; i < 11; i++)
            send_request(fecs_pkg::OP_SPREAD, 16'(20000 - 322 * i),
                         (i % 2 == 0) ? 2'd2 : DECAY_OVER);
        pause_until_drained();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            request_idle_pct = sender_pct[ph];
            result_stall_pct = receiver_pct[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                pick_request(op, spot, decay);
                send_request(op, spot, decay);
            end
            // Hold off between phases until every result is back.
            pause_until_drained();
        end

        // Allow for any result beyond those expected to show itself.
        result_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d writes, %0d outside the grid,",
                 grid_tracker.requests, grid_tracker.writes, grid_tracker.outside);
        $display("%0d spreads clamped at level zero and %0d bottom-row spreads.",
                 grid_tracker.floored, grid_tracker.bottom_spreads);
        if (grid_tracker.failures == 0 && grid_tracker.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
